// ===== hw/rtl/sts_pkg.sv =====
// ============================================================================
// sts_pkg
// Shared types, constants and the reciprocal table of the threshold smoother.
// ============================================================================
package sts_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int PIX_W      = 8;
    localparam int DIM_W      = 12;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // centre weight 4 plus up to six accepted neighbours
    localparam int CENTRE_WEIGHT = 4;
    localparam int NB_COUNT      = 6;
    localparam int NACC_W        = 3;
    localparam int SUM_W         = 12;   // 4*255 + 6*255 = 2550
    localparam int RECIP_W       = 15;   // 65536/4 = 16384
    localparam int PROD_W        = SUM_W + RECIP_W;
    localparam int FRAC_W        = 16;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd30;
    localparam logic [DIM_W-1:0] WIDTH_RST     = 12'd720;
    localparam logic [DIM_W-1:0] HEIGHT_RST    = 12'd576;
    localparam logic [DIM_W-1:0] MIN_DIM       = 12'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } t_cfg_idx;

    // one classified interior pixel, handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [NACC_W-1:0] nacc;
        logic              last;
    } t_item;

    // floor(65536 / (4 + nacc))
    function automatic logic [RECIP_W-1:0] recip(input logic [NACC_W-1:0] nacc);
        logic [RECIP_W-1:0] r;
        begin
            case (nacc)
                3'd0:    r = 15'd16384;
                3'd1:    r = 15'd13107;
                3'd2:    r = 15'd10922;
                3'd3:    r = 15'd9362;
                3'd4:    r = 15'd8192;
                3'd5:    r = 15'd7281;
                default: r = 15'd6553;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/sts_front.sv =====
// ============================================================================
// sts_front
// Raster counters, line store, window and neighbour classification.
// ============================================================================
module sts_front #(
    parameter int MAX_WIDTH = sts_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [sts_pkg::PIX_W-1:0]   i_cur,
    input  logic [sts_pkg::PIX_W-1:0]   i_prv,
    input  logic [sts_pkg::PIX_W-1:0]   i_nxt,
    input  logic                        i_sof,
    input  logic [sts_pkg::THR_W-1:0]   i_threshold,
    input  logic [sts_pkg::DIM_W-1:0]   i_frame_width,
    input  logic [sts_pkg::DIM_W-1:0]   i_frame_height,
    output logic                        o_busy,
    output logic                        o_push,
    output sts_pkg::t_item              o_item
);

    localparam int CNT_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = ($clog2(MAX_WIDTH + 1) > sts_pkg::DIM_W) ?
                           $clog2(MAX_WIDTH + 1) : sts_pkg::DIM_W;
    localparam int PW    = sts_pkg::PIX_W;
    localparam int WORD_W = 4 * PW;
    localparam logic [WW-1:0] MAX_W_V = WW'(MAX_WIDTH);
    localparam logic [WW-1:0] MIN_W_V = WW'(sts_pkg::MIN_DIM);

    // ---------------- stage 0: position and line store read ----------------
    logic [CNT_W-1:0]          r_col, n_col, w_c;
    logic [sts_pkg::DIM_W-1:0] r_row, n_row, w_r, w_h;
    logic [WW-1:0]             w_w, w_fw, w_c_ext, w_c_nx;
    logic                      w_int, w_last;

    always_comb begin
        w_fw = WW'(i_frame_width);
        if (w_fw < MIN_W_V) begin
            w_w = MIN_W_V;
        end else if (w_fw > MAX_W_V) begin
            w_w = MAX_W_V;
        end else begin
            w_w = w_fw;
        end
        w_h = (i_frame_height < sts_pkg::MIN_DIM) ? sts_pkg::MIN_DIM : i_frame_height;

        w_c     = i_sof ? '0 : r_col;
        w_r     = i_sof ? '0 : r_row;
        w_c_ext = WW'(w_c);
        w_c_nx  = w_c_ext + WW'(1);

        w_int  = (w_r >= 12'd2) && (w_r < w_h) && (w_c_ext >= WW'(2)) && (w_c_ext < w_w);
        w_last = (w_r == w_h - 12'd1) && (w_c_ext == w_w - WW'(1));

        if (w_c_nx >= w_w) begin
            n_col = '0;
            n_row = ({1'b0, w_r} + 13'd1 >= {1'b0, w_h}) ? '0 : w_r + 12'd1;
        end else begin
            n_col = CNT_W'(w_c_nx);
            n_row = w_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_valid) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line store word: above | mid | prev-frame | next-frame, lowest first
    logic [WORD_W-1:0] r_mem [MAX_WIDTH];
    logic [WORD_W-1:0] r_rd;
    logic [WORD_W-1:0] w_wr_word;

    // ---------------- stage 1 registers ----------------
    logic              r_s1_valid, r_s1_int, r_s1_last, r_s1_fwd;
    logic [CNT_W-1:0]  r_s1_addr;
    logic [PW-1:0]     r_s1_cur, r_s1_prv, r_s1_nxt;
    logic [WORD_W-1:0] r_fwd_word;

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_rd <= r_mem[w_c];
        end
        if (r_s1_valid) begin
            r_mem[r_s1_addr] <= w_wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_int   <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            if (i_valid) begin
                r_s1_int  <= w_int;
                r_s1_last <= w_last;
                // same column being written this cycle: read returns stale data
                r_s1_fwd  <= r_s1_valid && (r_s1_addr == w_c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_s1_addr  <= w_c;
            r_s1_cur   <= i_cur;
            r_s1_prv   <= i_prv;
            r_s1_nxt   <= i_nxt;
            r_fwd_word <= w_wr_word;
        end
    end

    // ---------------- stage 1: window and classification ----------------
    logic [WORD_W-1:0] w_rd_word;
    logic [PW-1:0]     w_above, w_mid, w_pd, w_nd;
    logic [PW-1:0]     r_win [6];   // 0 up, 1 centre, 2 left, 3 down, 4 prev, 5 next

    assign w_rd_word = r_s1_fwd ? r_fwd_word : r_rd;
    assign w_above   = w_rd_word[0*PW +: PW];
    assign w_mid     = w_rd_word[1*PW +: PW];
    assign w_pd      = w_rd_word[2*PW +: PW];
    assign w_nd      = w_rd_word[3*PW +: PW];
    assign w_wr_word = {r_s1_nxt, r_s1_prv, r_s1_cur, w_mid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_s1_valid) begin
            r_win[0] <= w_above;
            r_win[1] <= w_mid;
            r_win[2] <= r_win[1];
            r_win[3] <= r_s1_cur;
            r_win[4] <= w_pd;
            r_win[5] <= w_nd;
        end
    end

    logic [PW-1:0]                  w_nb [sts_pkg::NB_COUNT];
    logic [PW-1:0]                  w_diff;
    logic [sts_pkg::SUM_W-1:0]      w_sum;
    logic [sts_pkg::NACC_W-1:0]     w_nacc;

    always_comb begin
        w_nb[0] = r_win[5];
        w_nb[1] = r_win[4];
        w_nb[2] = r_win[2];
        w_nb[3] = w_mid;
        w_nb[4] = r_win[3];
        w_nb[5] = r_win[0];
        w_sum   = sts_pkg::SUM_W'(r_win[1]) * sts_pkg::SUM_W'(sts_pkg::CENTRE_WEIGHT);
        w_nacc  = '0;
        w_diff  = '0;
        for (int k = 0; k < sts_pkg::NB_COUNT; k++) begin
            w_diff = (w_nb[k] > r_win[1]) ? w_nb[k] - r_win[1] : r_win[1] - w_nb[k];
            if (w_diff < i_threshold) begin
                w_sum  = w_sum + sts_pkg::SUM_W'(w_nb[k]);
                w_nacc = w_nacc + 3'd1;
            end
        end
    end

    assign o_busy      = r_s1_valid;
    assign o_push      = r_s1_valid && r_s1_int;
    assign o_item.sum  = w_sum;
    assign o_item.nacc = w_nacc;
    assign o_item.last = r_s1_last;

endmodule

// ===== hw/rtl/sts_queue.sv =====
// ============================================================================
// sts_queue
// Short FIFO of classified pixels between front and back.
// ============================================================================
module sts_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  sts_pkg::t_item              i_item,
    input  logic                        i_pop,
    output logic                        o_valid,
    output sts_pkg::t_item              o_item,
    output logic [sts_pkg::QLVL_W-1:0]  o_level
);

    localparam logic [sts_pkg::QPTR_W-1:0] LAST_PTR = sts_pkg::QPTR_W'(sts_pkg::QDEPTH - 1);

    sts_pkg::t_item                r_data [sts_pkg::QDEPTH];
    logic [sts_pkg::QPTR_W-1:0]    r_wptr, r_rptr;
    logic [sts_pkg::QLVL_W-1:0]    r_level, n_level;

    always_comb begin
        n_level = r_level;
        if (i_push && !i_pop) begin
            n_level = r_level + sts_pkg::QLVL_W'(1);
        end else if (!i_push && i_pop) begin
            n_level = r_level - sts_pkg::QLVL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_level <= n_level;
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + sts_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + sts_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_item;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_item  = r_data[r_rptr];
    assign o_level = r_level;

endmodule

// ===== hw/rtl/sts_back.sv =====
// ============================================================================
// sts_back
// Reciprocal multiply and registered output stage.
// ============================================================================
module sts_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  sts_pkg::t_item              i_item,
    output logic                        o_pop,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [sts_pkg::PIX_W-1:0]   o_pixel,
    output logic                        o_last
);

    logic [sts_pkg::PROD_W-1:0] w_prod;
    logic                       r_valid;
    logic [sts_pkg::PIX_W-1:0]  r_pixel;
    logic                       r_last;

    assign w_prod = sts_pkg::PROD_W'(i_item.sum) *
                    sts_pkg::PROD_W'(sts_pkg::recip(i_item.nacc));
    assign o_pop  = i_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pixel <= w_prod[sts_pkg::FRAC_W +: sts_pkg::PIX_W];
            r_last  <= i_item.last;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_last  = r_last;

endmodule

// ===== hw/rtl/spatiotemporal_threshold_smoother.sv =====
// ============================================================================
// spatiotemporal_threshold_smoother
// Luma denoiser: 3x3 cross plus previous/next frame taps, threshold gated.
// ============================================================================
// Datapath: the line store is read at the transfer edge, the pixel is
//   classified and enqueued, then multiplied into the output register.
// Throughput: one pixel per clock, one line store read and one write per pixel;
//   input stalls only when queue plus classify stage hold four pixels.
// Reset (synchronous, active low): counters to (0,0), window to zero,
//   registers to threshold 30, 720x576; line store contents are not cleared.
// ============================================================================
module spatiotemporal_threshold_smoother #(
    parameter int MAX_WIDTH = sts_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [sts_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sts_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // pixel input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,  // cur_pixel, prev_pixel, next_pixel
    input  logic                            s_axis_tuser,  // start_of_frame
    // filtered output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // filtered_pixel
    output logic                            m_axis_tlast   // last_of_frame
);

    // ------------------------------------------------------------------
    // Configuration registers; the user must write them only while the pipe is idle (not enforced here).
    // ------------------------------------------------------------------
    logic [sts_pkg::THR_W-1:0] r_threshold;
    logic [sts_pkg::DIM_W-1:0] r_frame_width;
    logic [sts_pkg::DIM_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= sts_pkg::THRESHOLD_RST;
            r_frame_width  <= sts_pkg::WIDTH_RST;
            r_frame_height <= sts_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sts_pkg::CFG_THRESHOLD:    r_threshold    <= i_cfg_data[sts_pkg::THR_W-1:0];
                sts_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                sts_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front end: takes a pixel whenever the queue has room for it and
    // for the one still in the classify stage. Each transfer is one
    // line store read; border pixels are dropped before the queue.
    // ------------------------------------------------------------------
    logic                          w_in_xfer;
    logic                          w_busy;
    logic                          w_push;
    sts_pkg::t_item                w_push_item;
    logic [sts_pkg::QLVL_W-1:0]    w_level;
    logic [sts_pkg::QLVL_W:0]      w_committed;

    assign w_committed   = {1'b0, w_level} + (sts_pkg::QLVL_W + 1)'(w_busy);
    assign s_axis_tready = (w_committed < (sts_pkg::QLVL_W + 1)'(sts_pkg::QDEPTH));
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    sts_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_in_xfer),
        .i_cur          (s_axis_tdata[7:0]),
        .i_prv          (s_axis_tdata[15:8]),
        .i_nxt          (s_axis_tdata[23:16]),
        .i_sof          (s_axis_tuser),
        .i_threshold    (r_threshold),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_busy         (w_busy),
        .o_push         (w_push),
        .o_item         (w_push_item)
    );

    // ------------------------------------------------------------------
    // Queue: decouples front from downstream backpressure.
    // ------------------------------------------------------------------
    logic           w_head_valid;
    sts_pkg::t_item w_head_item;
    logic           w_pop;

    sts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_item  (w_head_item),
        .o_level (w_level)
    );

    // ------------------------------------------------------------------
    // Back end: sum * floor(65536/divisor) >> 16 into the output register.
    // ------------------------------------------------------------------
    sts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_head_valid),
        .i_item  (w_head_item),
        .o_pop   (w_pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_pixel (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // queued plus in-flight pixels never exceed the queue depth
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_committed <= (sts_pkg::QLVL_W + 1)'(sts_pkg::QDEPTH))
        else $error("queue overcommitted");

    // every input transfer reaches the classify stage next cycle
    a_front_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> w_busy)
        else $error("front stage lost a transfer");

    // a pixel pushed into an empty queue is at the head next cycle
    a_queue_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && (w_level == '0)) |=> w_head_valid)
        else $error("queue head missing after push");

endmodule
